FILE: rtl/hfc_pkg.sv
// hfc_pkg: shared types, constants and the byte-wide crc update for the frame checker
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package hfc_pkg;

  // longest frame that still passes; longer frames report too long
  localparam int unsigned MAX_LEN   = 64;
  localparam int unsigned MIN_FRAME = 6;

  localparam logic [7:0]  HDR0          = 8'hAB;
  localparam logic [7:0]  HDR1          = 8'hCD;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [7:0]  CNT_MAX       = 8'hFF;
  localparam int unsigned TAIL_DEPTH    = 4;

  typedef enum logic [2:0] {
    ST_OK           = 3'd0,
    ST_BAD_HEADER   = 3'd1,
    ST_CRC_MISMATCH = 3'd2,
    ST_TOO_SHORT    = 3'd3,
    ST_TOO_LONG     = 3'd4
  } frame_status_t;

  typedef struct packed {
    frame_status_t status;
    logic [7:0]    length;
  } frame_result_t;

  // crc-16/kermit, reflected, one byte per call
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY_REFL;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

endpackage

FILE: rtl/hfc_in_stage.sv
// hfc_in_stage: input register for one received byte and its end flag
// depends on hfc_pkg
`timescale 1ns / 1ps

module hfc_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_frame,
  input  logic       take,
  output logic       item_valid,
  output logic [7:0] item_data,
  output logic       item_eof
);
  import hfc_pkg::*;

  logic       vld_r;
  logic [7:0] data_r;
  logic       eof_r;

  assign in_ready   = !vld_r || take;
  assign item_valid = vld_r;
  assign item_data  = data_r;
  assign item_eof   = eof_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      vld_r <= 1'b1;
    end else if (take) begin
      vld_r <= 1'b0;
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data_byte;
      eof_r  <= in_end_of_frame;
    end
  end

endmodule

FILE: rtl/hfc_frame_core.sv
// hfc_frame_core: per-frame state (count, header flag, tail delay line, crc) and status decision
// depends on hfc_pkg
`timescale 1ns / 1ps

module hfc_frame_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  item_valid,
  input  logic [7:0]            item_data,
  input  logic                  item_eof,
  input  logic                  res_free,
  output logic                  go,
  output logic                  res_load,
  output hfc_pkg::frame_result_t res
);
  import hfc_pkg::*;

  logic [7:0]  cnt_r, cnt_nxt;
  logic        ovf_r, ovf_nxt;
  logic [15:0] crc_r, crc_nxt;
  logic [7:0]  tail_r [TAIL_DEPTH];
  logic [7:0]  tail_nxt [TAIL_DEPTH];
  logic        hdr_ok_r, hdr_ok_nxt;

  logic [15:0] received;
  logic        last;

  // a last byte needs room in the result register
  assign go       = item_valid && (!item_eof || res_free);
  assign last     = go && item_eof;
  assign res_load = last;

  always_comb begin
    hdr_ok_nxt = hdr_ok_r;
    if (!ovf_r && cnt_r == 8'd0 && item_data != HDR0) begin
      hdr_ok_nxt = 1'b0;
    end
    if (!ovf_r && cnt_r == 8'd1 && item_data != HDR1) begin
      hdr_ok_nxt = 1'b0;
    end

    // oldest byte leaves the delay line into the crc once it is body
    crc_nxt = crc_r;
    if (ovf_r || cnt_r >= 8'(MIN_FRAME)) begin
      crc_nxt = crc_feed(crc_r, tail_r[TAIL_DEPTH-1]);
    end

    tail_nxt[0] = item_data;
    for (int i = 1; i < TAIL_DEPTH; i++) begin
      tail_nxt[i] = tail_r[i-1];
    end

    if (cnt_r == CNT_MAX) begin
      cnt_nxt = cnt_r;
      ovf_nxt = 1'b1;
    end else begin
      cnt_nxt = cnt_r + 8'd1;
      ovf_nxt = ovf_r;
    end
  end

  // crc low byte at length-4, high byte at length-3
  assign received = {tail_nxt[2], tail_nxt[3]};

  always_comb begin
    res.length = cnt_nxt;
    if (!ovf_nxt && cnt_nxt < 8'(MIN_FRAME)) begin
      res.status = ST_TOO_SHORT;
    end else if (ovf_nxt || cnt_nxt > 8'(MAX_LEN)) begin
      res.status = ST_TOO_LONG;
    end else if (!hdr_ok_nxt) begin
      res.status = ST_BAD_HEADER;
    end else if (received != crc_nxt) begin
      res.status = ST_CRC_MISMATCH;
    end else begin
      res.status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || last) begin
      cnt_r    <= 8'd0;
      ovf_r    <= 1'b0;
      crc_r    <= 16'h0000;
      hdr_ok_r <= 1'b1;
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tail_r[i] <= 8'h00;
      end
    end else if (go) begin
      cnt_r    <= cnt_nxt;
      ovf_r    <= ovf_nxt;
      crc_r    <= crc_nxt;
      hdr_ok_r <= hdr_ok_nxt;
      for (int i = 0; i < TAIL_DEPTH; i++) begin
        tail_r[i] <= tail_nxt[i];
      end
    end
  end

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    last |=> (cnt_r == 8'd0 && !ovf_r && crc_r == 16'h0000 && hdr_ok_r))
    else $error("frame state not cleared after last item");

  a_ovf_saturated: assert property (@(posedge clk) disable iff (!rst_n)
    ovf_r |-> cnt_r == CNT_MAX)
    else $error("overflow flag set without saturated count");

  a_bad_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !item_eof && !ovf_r && cnt_r == 8'd0 && item_data != HDR0) |=> !hdr_ok_r)
    else $error("wrong first header byte not flagged");

  a_count_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (go && !item_eof && cnt_r != CNT_MAX) |=> cnt_r == $past(cnt_r) + 8'd1)
    else $error("byte count did not advance");

endmodule

FILE: rtl/hfc_out_stage.sv
// hfc_out_stage: result register holding status and length until taken
// depends on hfc_pkg
`timescale 1ns / 1ps

module hfc_out_stage (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  res_load,
  input  hfc_pkg::frame_result_t res,
  output logic                  res_free,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [2:0]            out_frame_status,
  output logic [7:0]            out_frame_length
);
  import hfc_pkg::*;

  logic          vld_r;
  frame_result_t res_r;

  assign res_free         = !vld_r || out_ready;
  assign out_valid        = vld_r;
  assign out_frame_status = res_r.status;
  assign out_frame_length = res_r.length;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (res_load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_r <= res;
    end
  end

endmodule

FILE: rtl/header_crc16_frame_checker_unit.sv
// header_crc16_frame_checker_unit: top level of the received-frame checker
// depends on hfc_pkg, hfc_in_stage, hfc_frame_core, hfc_out_stage
`timescale 1ns / 1ps

// Checks received frames one byte per item. A frame starts with 0xAB 0xCD, carries a body
// covered by crc-16/kermit (reflected 0x1021, init 0, no final xor), then the crc low byte,
// the crc high byte and two unchecked trailer bytes; in_end_of_frame marks the last byte.
// Only the last byte of a frame produces a result item: status (0 ok, 1 bad header,
// 2 crc mismatch, 3 too short, 4 too long, first matching cause in the order too short,
// too long, bad header, crc mismatch) and the frame length saturating at 255. Frames under
// 6 bytes are too short; over MAX_LEN (64) bytes, or over 255, are too long.
// Throughput is one byte per clock cycle unless a last byte waits for room in the result
// register; a result item is held in the result register and offered on out_valid.
// The cycle is bounded by the byte-wide crc update followed by the 16-bit
// compare against the received crc. A byte reaches the crc only after passing a four-entry
// delay line, so the trailing crc and trailer bytes never enter it.
module header_crc16_frame_checker_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_data_byte,
  input  logic       in_end_of_frame,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [2:0] out_frame_status,
  output logic [7:0] out_frame_length
);
  import hfc_pkg::*;

  // input register to core
  logic          item_valid;
  logic [7:0]    item_data;
  logic          item_eof;
  logic          go;

  // core to result register
  logic          res_load;
  logic          res_free;
  frame_result_t res;

  hfc_in_stage u_in (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_byte    (in_data_byte),
    .in_end_of_frame (in_end_of_frame),
    .take            (go),
    .item_valid      (item_valid),
    .item_data       (item_data),
    .item_eof        (item_eof)
  );

  // per-frame state; stalls only when a last byte meets a full result register
  hfc_frame_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_valid (item_valid),
    .item_data  (item_data),
    .item_eof   (item_eof),
    .res_free   (res_free),
    .go         (go),
    .res_load   (res_load),
    .res        (res)
  );

  hfc_out_stage u_out (
    .clk              (clk),
    .rst_n            (rst_n),
    .res_load         (res_load),
    .res              (res),
    .res_free         (res_free),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_frame_status (out_frame_status),
    .out_frame_length (out_frame_length)
  );

endmodule
